>>> rtl/ptsr_pkg.sv
// Shared constants, codes and types of the parent-table source-route builder.
`default_nettype none

package ptsr_pkg;

  // Table and path sizes.
  localparam int TABLE_ENTRIES = 32;
  localparam int PATH_DEPTH    = 10;

  localparam int IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
  localparam int PATH_IDX_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int LEN_W      = $clog2(PATH_DEPTH + 1);

  localparam int ADDR_W = 16;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOPARENT = 3'd2,
    ST_LOOP     = 3'd3,
    ST_LONG     = 3'd4
  } ptsr_status_t;

  // Configuration register indexes.
  localparam logic CFG_SINK  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // A lookup travelling down the chain of cells.
  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] key;
    logic              found;
    logic [ADDR_W-1:0] parent;
    logic [IDX_W-1:0]  idx;
  } ptsr_token_t;

  // A write into one cell of the table.
  typedef struct packed {
    logic              en;
    logic              key_en;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] parent;
  } ptsr_wr_t;

endpackage

`default_nettype wire

>>> rtl/ptsr_query_if.sv
// Input channel: one add or route request per transfer.
`default_nettype none

interface ptsr_query_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] node_address;
  logic [15:0] parent_address;

  modport source (output valid, mode, node_address, parent_address, input ready);
  modport sink   (input valid, mode, node_address, parent_address, output ready);
endinterface

`default_nettype wire

>>> rtl/ptsr_result_if.sv
// Output channel: one result item per transfer.
`default_nettype none

interface ptsr_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] hop_address;
  logic [3:0]  hop_position;
  logic [3:0]  route_length;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, hop_address, hop_position, route_length, status, last,
                  input ready);
  modport sink   (input valid, hop_address, hop_position, route_length, status, last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ptsr_cell.sv
// One table cell: holds a child/parent link and checks the passing lookup against it.
`default_nettype none

module ptsr_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ptsr_pkg::IDX_W-1:0] cell_index,
  input  wire logic                     occupied,
  input  wire ptsr_pkg::ptsr_wr_t       wr,
  input  wire ptsr_pkg::ptsr_token_t    tok_in,
  output ptsr_pkg::ptsr_token_t         tok_out
);
  import ptsr_pkg::*;

  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] parent;
  logic              hit;
  ptsr_token_t       tok_next;

  // The first occupied cell whose key matches claims the lookup.
  assign hit = tok_in.active && !tok_in.found && occupied && (key == tok_in.key);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found  = 1'b1;
      tok_next.parent = parent;
      tok_next.idx    = cell_index;
    end
  end

  // Hand the lookup on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Link storage, written by the controller.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_index)) begin
      if (wr.key_en) begin
        key <= wr.key;
      end
      parent <= wr.parent;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ptsr_chain.sv
// Row of table cells through which each lookup travels one cell per cycle.
`default_nettype none

module ptsr_chain (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ptsr_pkg::CNT_W-1:0] entry_count,
  input  wire ptsr_pkg::ptsr_wr_t       wr,
  input  wire ptsr_pkg::ptsr_token_t    head,
  output ptsr_pkg::ptsr_token_t         tail
);
  import ptsr_pkg::*;

  ptsr_token_t tok [TABLE_ENTRIES+1];

  assign tok[0] = head;
  assign tail   = tok[TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic occupied;

    // Only entries below the fill count hold a link.
    assign occupied = (CNT_W'(i) < entry_count);

    ptsr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .occupied   (occupied),
      .wr         (wr),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

endmodule

`default_nettype wire

>>> rtl/parent_table_source_route_builder.sv
// Top level of the parent-table source-route builder: control, path buffer and result register.
`default_nettype none

// The block keeps up to TABLE_ENTRIES child/parent links in a chain of cells. Every table
// lookup sends the key down the whole chain, one cell a cycle. An add item takes one
// lookup and then hands over its result. A route item takes one lookup per hop visited,
// then emits its hops one result at a time, each held back while the output register is
// full. One item is worked on at a time; the next is taken once the last result of the
// current item sits in the output register.
// Configuration writes apply at once and must only be made while the block is idle.
module parent_table_source_route_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  ptsr_query_if.sink       query,
  ptsr_result_if.source    result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ptsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_PUSH = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;

  logic [ADDR_W-1:0] sink_address;
  logic [3:0]        hop_limit;
  logic [LEN_W-1:0]  limit_eff;

  logic [CNT_W-1:0]  entry_count;
  logic              mode_q;
  logic [ADDR_W-1:0] parent_q;
  logic [ADDR_W-1:0] cur;
  logic              launch;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  k;
  logic [LEN_W-1:0]  rd_pos;
  logic [ADDR_W-1:0] path [PATH_DEPTH];
  ptsr_status_t      res_status;

  ptsr_token_t       head;
  ptsr_token_t       tail;
  ptsr_wr_t          wr;

  logic              accept;
  logic              out_free;
  logic              tail_here;
  logic              on_path;
  logic              table_full;
  logic              emit_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sink_address <= 16'd1;
      hop_limit    <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SINK:  sink_address <= cfg_data;
        CFG_LIMIT: hop_limit    <= cfg_data[3:0];
        default:   ;
      endcase
    end
  end

  // A hop limit of zero acts as one; above the path depth it is clipped.
  always_comb begin
    if (hop_limit == 4'd0) begin
      limit_eff = LEN_W'(1);
    end else if (32'(hop_limit) > PATH_DEPTH) begin
      limit_eff = LEN_W'(PATH_DEPTH);
    end else begin
      limit_eff = LEN_W'(hop_limit);
    end
  end

  assign accept     = query.valid && query.ready;
  assign query.ready = (state == S_IDLE);
  assign out_free   = !result.valid || result.ready;
  assign tail_here  = (state == S_WALK) && tail.active;
  assign table_full = (entry_count == CNT_W'(TABLE_ENTRIES));

  // Lookup launched into the chain.
  always_comb begin
    head        = '0;
    head.active = launch;
    head.key    = cur;
  end

  ptsr_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .wr          (wr),
    .head        (head),
    .tail        (tail)
  );

  // Is the found parent already on the path walked so far?
  always_comb begin
    on_path = 1'b0;
    for (int i = 0; i < PATH_DEPTH; i++) begin
      if ((LEN_W'(i) < len) && (path[i] == tail.parent)) begin
        on_path = 1'b1;
      end
    end
  end

  // Table write when an add lookup returns: update a known child or append a new one while the table has room.
  always_comb begin
    wr        = '0;
    wr.key    = cur;
    wr.parent = parent_q;
    if (tail_here && !mode_q) begin
      if (tail.found) begin
        wr.en  = 1'b1;
        wr.idx = tail.idx;
      end else if (!table_full) begin
        wr.en     = 1'b1;
        wr.key_en = 1'b1;
        wr.idx    = entry_count[IDX_W-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (tail.active) begin
          if (mode_q && tail.found && (tail.parent != '0) && !on_path &&
              (tail.parent == sink_address)) begin
            state_next = S_EMIT;
          end else if (!mode_q || !tail.found || (tail.parent == '0) || on_path ||
                       (len >= limit_eff)) begin
            state_next = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free && emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk control: fill count and launch pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      launch      <= 1'b0;
    end else begin
      launch <= accept || (tail_here && mode_q && (state_next == S_WALK));
      if (wr.en && wr.key_en) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  // Item registers, path buffer and status of a single-result item.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= query.mode;
      cur      <= query.node_address;
      parent_q <= query.parent_address;
      path[0]  <= query.node_address;
      len      <= LEN_W'(1);
    end else if (tail_here) begin
      if (!mode_q) begin
        res_status <= (tail.found || !table_full) ? ST_OK : ST_FULL;
      end else if (!tail.found || (tail.parent == '0)) begin
        res_status <= ST_NOPARENT;
      end else if (on_path) begin
        res_status <= ST_LOOP;
      end else if (tail.parent == sink_address) begin
        res_status <= ST_OK;
      end else if (len >= limit_eff) begin
        res_status <= ST_LONG;
      end else begin
        cur                       <= tail.parent;
        path[len[PATH_IDX_W-1:0]] <= tail.parent;
        len                       <= len + LEN_W'(1);
      end
    end
  end

  // Hop counter for the emit phase, counted from the sink side.
  assign rd_pos    = len - k - LEN_W'(1);
  assign emit_last = ((k + LEN_W'(1)) == len);

  always_ff @(posedge clk) begin
    if (state == S_WALK) begin
      k <= '0;
    end else if ((state == S_EMIT) && out_free) begin
      k <= k + LEN_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == S_PUSH) && out_free) begin
      result.valid <= 1'b1;
    end else if ((state == S_EMIT) && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUSH) && out_free) begin
      result.hop_address  <= '0;
      result.hop_position <= '0;
      result.route_length <= '0;
      result.status       <= res_status;
      result.last         <= 1'b1;
    end else if ((state == S_EMIT) && out_free) begin
      result.hop_address  <= path[rd_pos[PATH_IDX_W-1:0]];
      result.hop_position <= 4'(k);
      result.route_length <= 4'(len);
      result.status       <= ST_OK;
      result.last         <= emit_last;
    end
  end

endmodule

`default_nettype wire

>>> verif/ptsr_tb_pkg.sv
// Request codes shared by the route builder testbench and its checker.
`default_nettype none

package ptsr_tb_pkg;

  // Kind of request carried by one transfer on the query channel.
  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_ROUTE = 1'b1
  } ptsr_mode_t;

endpackage

`default_nettype wire

>>> verif/parent_table_source_route_builder_checker.sv
// Checker for the route builder: mirrors the parent table, predicts every result and compares.
`default_nettype none

module parent_table_source_route_builder_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  ptsr_query_if            qry,
  ptsr_result_if           res,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending_count,
  output int               results_checked
);
  import ptsr_pkg::*;
  import ptsr_tb_pkg::*;

  localparam int PRINT_CAP = 60;

  // One expected result transfer.
  typedef struct packed {
    logic [15:0]  hop;
    logic [3:0]   pos;
    logic [3:0]   len;
    ptsr_status_t status;
    logic         last;
  } hop_rec_t;

  // Mirror of the block's table and registers.
  logic [15:0] link_child  [TABLE_ENTRIES];
  logic [15:0] link_parent [TABLE_ENTRIES];
  int          link_count;
  logic [15:0] sink_reg;
  logic [3:0]  limit_reg;

  hop_rec_t expected_hops [$];

  // Prints one line per mismatch, up to a cap, and always counts it.
  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                results_checked, name, got, want));
    end
  endtask

  // Slot of a child in the mirrored table, or -1 when it is absent.
  function automatic int find_link(logic [15:0] child);
    for (int i = 0; i < link_count; i++) begin
      if (link_child[i] == child) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Works out the results of one accepted request and queues them.
  task automatic predict_route_hops(logic req_mode, logic [15:0] node, logic [15:0] parent);
    int           slot;
    int           steps;
    int           cap;
    bit           stop;
    ptsr_status_t verdict;
    logic [15:0]  here;
    logic [15:0]  up;
    logic [15:0]  walk [PATH_DEPTH];
    verdict = ST_OK;
    if (req_mode == MODE_ADD) begin
      // A known child is always updated; a new one needs a free slot.
      slot = find_link(node);
      if (slot >= 0) begin
        link_parent[slot] = parent;
      end else if (link_count >= TABLE_ENTRIES) begin
        verdict = ST_FULL;
      end else begin
        link_child[link_count]  = node;
        link_parent[link_count] = parent;
        link_count++;
      end
      expected_hops.push_back('{hop: '0, pos: '0, len: '0, status: verdict, last: 1'b1});
    end else begin
      // The hop limit is clamped into 1 .. PATH_DEPTH.
      if (limit_reg == 4'd0) begin
        cap = 1;
      end else if (limit_reg > PATH_DEPTH) begin
        cap = PATH_DEPTH;
      end else begin
        cap = limit_reg;
      end
      steps = 0;
      stop  = 1'b0;
      here  = node;
      while (!stop) begin
        walk[steps] = here;
        steps++;
        slot = find_link(here);
        if (slot < 0 || link_parent[slot] == 16'd0) begin
          verdict = ST_NOPARENT;
          stop    = 1'b1;
        end else begin
          up = link_parent[slot];
          // The node being visited is already on the walk, so a self link is a loop.
          for (int i = 0; i < steps; i++) begin
            if (walk[i] == up) begin
              verdict = ST_LOOP;
            end
          end
          if (verdict == ST_LOOP || up == sink_reg) begin
            stop = 1'b1;
          end else if (steps >= cap) begin
            verdict = ST_LONG;
            stop    = 1'b1;
          end else begin
            here = up;
          end
        end
      end
      if (verdict != ST_OK) begin
        expected_hops.push_back('{hop: '0, pos: '0, len: '0, status: verdict, last: 1'b1});
      end else begin
        // Hops leave sink side first, so the walk is replayed backwards.
        for (int k = 0; k < steps; k++) begin
          expected_hops.push_back('{hop: walk[steps - 1 - k], pos: 4'(k), len: 4'(steps),
                                    status: ST_OK, last: (k == steps - 1)});
        end
      end
    end
  endtask

  // Compares one result transfer with the oldest expectation.
  task automatic check_result();
    hop_rec_t want;
    if (expected_hops.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: hop %h status %0d",
                                res.hop_address, res.status));
    end else begin
      want = expected_hops.pop_front();
      results_checked++;
      compare_field("hop_address", res.hop_address, want.hop);
      compare_field("hop_position", res.hop_position, want.pos);
      compare_field("route_length", res.route_length, want.len);
      compare_field("status", res.status, want.status);
      compare_field("last", res.last, want.last);
    end
  endtask

  // Everything is sampled at the rising edge, where transfers and writes take effect.
  always @(posedge clk) begin
    if (rst) begin
      link_count = 0;
      sink_reg   = 16'd1;
      limit_reg  = 4'd10;
      expected_hops.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SINK) begin
          sink_reg = cfg_data;
        end else if (cfg_index == CFG_LIMIT) begin
          limit_reg = cfg_data[3:0];
        end
      end
      if (qry.valid && qry.ready) begin
        predict_route_hops(qry.mode, qry.node_address, qry.parent_address);
      end
      if (res.valid && res.ready) begin
        check_result();
      end
    end
    pending_count <= expected_hops.size();
  end

endmodule

`default_nettype wire

>>> verif/parent_table_source_route_builder_tb.sv
// Testbench top for the route builder: clock, reset, stimulus, result drain and verdict.
`default_nettype none

module parent_table_source_route_builder_tb;
  import ptsr_pkg::*;
  import ptsr_tb_pkg::*;

  localparam int ITEMS        = 460;
  localparam int POOL_SIZE    = TABLE_ENTRIES;
  localparam int GAP_MAX      = 17;
  localparam int LONG_HOLD    = 600;
  localparam int SETTING_SPAN = 50;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE       = 400;

  // How a random chain of links is closed off.
  typedef enum int {
    END_AT_SINK,
    END_IN_LOOP,
    END_BROKEN
  } chain_end_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  ptsr_query_if  qry ();
  ptsr_result_if res ();

  int fail_count;
  int pending_count;
  int results_checked;

  // Stimulus bookkeeping.
  bit [15:0]   node_pool [POOL_SIZE];
  logic [15:0] sink_now;
  bit          calm;
  bit          hold_request;
  int          requests_sent;
  int          routes_sent;
  int          settings_made;

  parent_table_source_route_builder u_top (
    .clk       (clk),
    .rst       (rst),
    .query     (qry),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  parent_table_source_route_builder_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .qry             (qry),
    .res             (res),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  always #10 clk = ~clk;

  // Idle cycles before the next transfer; none during calm stretches.
  function automatic int pick_gap();
    if (calm) begin
      return 0;
    end
    return $urandom_range(GAP_MAX, 0);
  endfunction

  function automatic bit in_pool(logic [15:0] addr);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (node_pool[i] == addr) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // An address that is neither a table member nor the current sink.
  function automatic logic [15:0] outsider();
    logic [15:0] addr;
    do begin
      addr = 16'($urandom);
    end while (in_pool(addr) || addr == sink_now);
    return addr;
  endfunction

  // Any address, weighted towards members, outsiders, the extremes and the sink.
  function automatic logic [15:0] pick_address();
    case ($urandom_range(4, 0))
      0:       return node_pool[$urandom_range(POOL_SIZE - 1, 0)];
      1:       return outsider();
      2:       return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      3:       return sink_now;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one request and returns at the edge of its transfer, valid still high.
  task automatic send_query(ptsr_mode_t op, logic [15:0] node, logic [15:0] parent);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      qry.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    qry.valid          <= 1'b1;
    qry.mode           <= op;
    qry.node_address   <= node;
    qry.parent_address <= parent;
    @(posedge clk);
    while (!qry.ready) @(posedge clk);
    requests_sent++;
    if (op == MODE_ROUTE) begin
      routes_sent++;
    end
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain_results();
    qry.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Writes both registers while the block is idle.
  task automatic set_config(logic [15:0] sink, logic [3:0] limit);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SINK;
    cfg_data  <= sink;
    @(posedge clk);
    // Bits above the hop limit carry random padding, which the block must drop.
    cfg_index <= CFG_LIMIT;
    cfg_data  <= {12'($urandom), limit};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sink_now  = sink;
    settings_made++;
  endtask

  // Links distinct members into a chain towards the sink, then asks for a route to its end.
  task automatic run_chain(int hops, chain_end_t ending);
    int          cand [POOL_SIZE - 1];
    logic [15:0] hop_node [PATH_DEPTH];
    logic [15:0] up_link  [PATH_DEPTH];
    int          pick;
    int          swap;
    int          idx;
    bit          backwards;
    for (int i = 0; i < POOL_SIZE - 1; i++) begin
      cand[i] = i + 1;
    end
    for (int i = 0; i < hops; i++) begin
      pick       = $urandom_range(POOL_SIZE - 2, i);
      swap       = cand[i];
      cand[i]    = cand[pick];
      cand[pick] = swap;
      hop_node[i] = node_pool[cand[i]];
      up_link[i]  = (i == 0) ? sink_now : hop_node[i - 1];
    end
    case (ending)
      END_IN_LOOP: up_link[0] = hop_node[$urandom_range(hops - 1, 0)];
      END_BROKEN: begin
        idx = $urandom_range(hops - 1, 0);
        up_link[idx] = $urandom_range(1, 0) ? 16'h0000 : outsider();
      end
      default: ;
    endcase
    backwards = $urandom_range(1, 0);
    for (int i = 0; i < hops; i++) begin
      idx = backwards ? hops - 1 - i : i;
      send_query(MODE_ADD, hop_node[idx], up_link[idx]);
    end
    send_query(MODE_ROUTE, hop_node[hops - 1], 16'($urandom));
    if ($urandom_range(3, 0) == 0) begin
      send_query(MODE_ROUTE, hop_node[$urandom_range(hops - 1, 0)], 16'($urandom));
    end
  endtask

  // Result side: a random stall before each transfer, or one long hold-off on request.
  initial begin : result_drain
    int stall;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
    end
  end

  // Cycle limit on the whole run.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("parent_table_source_route_builder test failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] cand_addr;
    logic [15:0] new_sink;
    logic [3:0]  new_limit;
    logic [3:0]  limit_plan [4];
    int          phase_idx;
    int          next_setting_at;
    int          roll;
    limit_plan = '{4'd10, 4'd1, 4'd15, 4'd0};

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SINK;
    cfg_data           <= 16'd0;
    qry.valid          <= 1'b0;
    qry.mode           <= MODE_ADD;
    qry.node_address   <= 16'd0;
    qry.parent_address <= 16'd0;
    calm         = 1'b0;
    hold_request = 1'b0;
    sink_now     = 16'd1;

    // Member addresses: both extremes, then distinct random ones clear of the reset sink.
    node_pool[0] = 16'h0000;
    node_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      do begin
        cand_addr = 16'($urandom);
      end while (cand_addr == 16'd1 || in_pool(cand_addr));
      node_pool[i] = cand_addr;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset register values.
    send_query(MODE_ROUTE, 16'hFFFF, 16'hFFFF);       // empty table: no parent
    send_query(MODE_ROUTE, 16'h0001, 16'h0000);       // the sink itself, with no entry
    send_query(MODE_ADD, node_pool[0], 16'h0001);     // node zero hangs off the sink
    send_query(MODE_ROUTE, node_pool[0], 16'h5A5A);   // one hop of address zero
    send_query(MODE_ADD, node_pool[1], 16'h0000);     // a stored parent of zero
    send_query(MODE_ROUTE, node_pool[1], 16'h0000);
    send_query(MODE_ADD, node_pool[1], 16'hFFFF);     // update into a self link
    send_query(MODE_ROUTE, node_pool[1], 16'hA5A5);
    for (int i = 2; i < 2 + PATH_DEPTH; i++) begin
      send_query(MODE_ADD, node_pool[i], (i == 2) ? 16'h0001 : node_pool[i - 1]);
    end
    send_query(MODE_ROUTE, node_pool[PATH_DEPTH + 1], 16'd0);  // full-depth route
    set_config(16'h0001, 4'd9);
    send_query(MODE_ROUTE, node_pool[PATH_DEPTH + 1], 16'd0);  // one hop too many
    set_config(16'h0001, 4'd0);
    send_query(MODE_ROUTE, node_pool[2], 16'd0);               // zero limit behaves as one
    send_query(MODE_ROUTE, node_pool[3], 16'd0);
    set_config(16'h0001, 4'd15);
    send_query(MODE_ROUTE, node_pool[PATH_DEPTH + 1], 16'd0);  // limit clamped to the depth
    send_query(MODE_ADD, node_pool[2], node_pool[3]);          // two-node loop
    send_query(MODE_ROUTE, node_pool[3], 16'd0);

    // Fill the rest of the table, then try a new child and an update while it is full.
    for (int i = 2 + PATH_DEPTH; i < POOL_SIZE; i++) begin
      send_query(MODE_ADD, node_pool[i], pick_address());
    end
    send_query(MODE_ADD, outsider(), 16'($urandom));
    send_query(MODE_ADD, node_pool[$urandom_range(POOL_SIZE - 1, 0)], 16'($urandom));

    // Random part: mostly well-formed chains with random members, the rest looped, broken or noise.
    phase_idx       = 0;
    next_setting_at = requests_sent;
    while (requests_sent < ITEMS) begin
      if (requests_sent >= next_setting_at) begin
        case (phase_idx % 5)
          0:       new_sink = 16'($urandom);
          1:       new_sink = 16'hFFFF;
          2:       new_sink = 16'h0000;
          3:       new_sink = node_pool[$urandom_range(POOL_SIZE - 1, 1)];
          default: new_sink = 16'h0001;
        endcase
        new_limit = (phase_idx < 4) ? limit_plan[phase_idx] : 4'($urandom);
        set_config(new_sink, new_limit);
        // Once, the result side holds off for long while requests keep coming.
        if (phase_idx == 3) begin
          hold_request = 1'b1;
        end
        phase_idx++;
        next_setting_at = requests_sent + SETTING_SPAN;
      end
      calm = ($urandom_range(4, 0) == 0);
      roll = $urandom_range(99, 0);
      if (roll < 65) begin
        run_chain($urandom_range(PATH_DEPTH, 1), END_AT_SINK);
      end else if (roll < 75) begin
        run_chain($urandom_range(PATH_DEPTH, 1), END_IN_LOOP);
      end else if (roll < 85) begin
        run_chain($urandom_range(PATH_DEPTH, 1), END_BROKEN);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_query(ptsr_mode_t'($urandom_range(1, 0)), pick_address(), pick_address());
        end
      end
      if ($urandom_range(9, 0) == 0) begin
        drain_results();
      end
    end

    // Let everything come out, then allow the latency of a full route on top.
    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d requests (%0d route queries) under %0d register settings.",
             requests_sent, routes_sent, settings_made + 1);
    $display("Checked %0d results; %0d mismatches, %0d still outstanding.",
             results_checked, fail_count, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("parent_table_source_route_builder test passed");
    end else begin
      $display("parent_table_source_route_builder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
